// ===== hw/rtl/drms_pkg.sv =====
// Shared types and constants for the dual motor ramp sequencer.
// No dependencies; the front end, back end, top level and testbench import this package.
package drms_pkg;

	// Configuration port geometry and register indexes
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_PWM_PERIOD = 1'b0;
	localparam logic REG_FLOOR_POWER = 1'b1;

	localparam logic [11:0] PWM_PERIOD_RESET = 12'd200;
	localparam logic [6:0] FLOOR_POWER_RESET = 7'd25;
	localparam logic [6:0] FULL_POWER = 7'd100;

	// Framing and command bytes
	localparam logic [7:0] BYTE_OPEN = 8'h01;
	localparam logic [7:0] BYTE_CLOSE = 8'h04;
	localparam logic [7:0] BYTE_FWD = 8'hF0;
	localparam logic [7:0] BYTE_RIGHT = 8'hF1;
	localparam logic [7:0] BYTE_LEFT = 8'hF2;
	localparam logic [7:0] BYTE_STOP = 8'hF3;

	// Division by 100 as a multiply by a rounded-up reciprocal: exact for products below 2^20
	localparam int unsigned DIV_SHIFT = 27;
	localparam logic [20:0] DIV_RECIP = 21'd1342178;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_FWD,
		OP_RIGHT,
		OP_LEFT,
		OP_STOP
	} drms_op_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} drms_item_t;

	typedef struct packed {
		logic [11:0] left_duty;
		logic [11:0] right_duty;
		logic        left_forward;
		logic        right_forward;
		logic        busy_res;
		logic        dropped;
	} drms_result_t;

	typedef struct packed {
		logic [1:0] inflight;
	} drms_back_status_t;

endpackage

// ===== hw/rtl/drms_fifo.sv =====
// Small first-word-fall-through queue built from registers.
// Depends only on its parameters; used for the command and result queues.
module drms_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           full,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
	assign rdata = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (do_pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/drms_front.sv =====
// Front end: frames received bytes into messages and turns each item into an operation.
// Depends on drms_pkg and drms_fifo (the operation queue towards the back end).
module drms_front
	import drms_pkg::*;
#(
	parameter int unsigned OP_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  drms_item_t cmd_item,
	input  logic       op_pop,
	output drms_op_t   op,
	output logic       op_empty
);

	logic in_message_q;
	logic accept;
	drms_op_t op_class;
	logic [2:0] op_bits;
	logic [$clog2(OP_DEPTH+1)-1:0] op_count;

	assign accept = push && !full;

	// Framing runs independently of the motor sequence, so it lives here.
	always_comb begin
		op_class = OP_NOP;
		if (cmd_item.cmd) begin
			op_class = OP_TICK;
		end else if (in_message_q) begin
			case (cmd_item.rx_byte)
				BYTE_FWD: op_class = OP_FWD;
				BYTE_RIGHT: op_class = OP_RIGHT;
				BYTE_LEFT: op_class = OP_LEFT;
				BYTE_STOP: op_class = OP_STOP;
				default: op_class = OP_NOP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_message_q <= 1'b0;
		end else if (accept && !cmd_item.cmd) begin
			if (!in_message_q && cmd_item.rx_byte == BYTE_OPEN) begin
				in_message_q <= 1'b1;
			end else if (in_message_q && cmd_item.rx_byte == BYTE_CLOSE) begin
				in_message_q <= 1'b0;
			end
		end
	end

	drms_fifo #(
		.WIDTH(3),
		.DEPTH(OP_DEPTH)
	) u_op_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(op_class),
		.pop(op_pop),
		.rdata(op_bits),
		.full(full),
		.empty(op_empty),
		.count(op_count)
	);

	assign op = drms_op_t'(op_bits);

	// The queue occupancy is not needed beyond full and empty.
	logic unused_count;
	assign unused_count = ^op_count;

endmodule

// ===== hw/rtl/drms_back.sv =====
// Back end: runs the stop / lift / ramp sequence and converts powers into duty counts.
// Depends on drms_pkg; fed from the front end's operation queue.
module drms_back
	import drms_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [11:0]       pwm_period,
	input  logic [6:0]        floor_power,
	input  drms_op_t          op,
	input  logic              op_empty,
	input  logic              go,
	output logic              op_pop,
	output drms_back_status_t status,
	output logic              res_valid,
	output drms_result_t      res
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_STOP,
		PH_LIFT,
		PH_RAMP
	} phase_t;

	phase_t phase_q, phase_d;
	logic [6:0] lpow_q, rpow_q, lpow_d, rpow_d;
	logic ldir_q, rdir_q, ldir_d, rdir_d;
	logic [1:0] pend_q, pend_d;
	logic ras_q, ras_d;
	logic busy, drop;

	// Stage 1: updated state
	logic v_s1, ldir_s1, rdir_s1, busy_s1, drop_s1;
	logic [6:0] lpow_s1, rpow_s1;
	logic [11:0] period_s1;
	// Stage 2: power times period
	logic v_s2, ldir_s2, rdir_s2, busy_s2, drop_s2;
	logic [18:0] lprod_s2, rprod_s2;
	logic [11:0] period_s2;
	// Stage 3: quotient by 100
	logic v_s3, ldir_s3, rdir_s3, busy_s3, drop_s3;
	logic [12:0] lq_s3, rq_s3;
	logic [11:0] period_s3;

	logic [39:0] lrecip, rrecip;

	assign op_pop = !op_empty && go;
	assign busy = (phase_q != PH_IDLE);

	always_comb begin
		phase_d = phase_q;
		lpow_d = lpow_q;
		rpow_d = rpow_q;
		ldir_d = ldir_q;
		rdir_d = rdir_q;
		pend_d = pend_q;
		ras_d = ras_q;
		drop = 1'b0;
		if (op == OP_TICK) begin
			case (phase_q)
				PH_STOP: begin
					if (lpow_q > floor_power || rpow_q > floor_power) begin
						if (lpow_q > floor_power) lpow_d = lpow_q - 7'd1;
						if (rpow_q > floor_power) rpow_d = rpow_q - 7'd1;
					end else begin
						lpow_d = '0;
						rpow_d = '0;
						phase_d = ras_q ? PH_LIFT : PH_IDLE;
					end
				end
				PH_LIFT: begin
					if (ras_q) begin
						ldir_d = pend_q[1];
						rdir_d = pend_q[0];
						ras_d = 1'b0;
					end
					if (lpow_q < floor_power || rpow_q < floor_power) begin
						lpow_d = floor_power;
						rpow_d = floor_power;
					end
					phase_d = PH_RAMP;
				end
				PH_RAMP: begin
					if (lpow_q < FULL_POWER) lpow_d = lpow_q + 7'd1;
					if (rpow_q < FULL_POWER) rpow_d = rpow_q + 7'd1;
					if (lpow_d >= FULL_POWER && rpow_d >= FULL_POWER) phase_d = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end else if (op inside {OP_FWD, OP_RIGHT, OP_LEFT, OP_STOP}) begin
			if (busy) begin
				drop = 1'b1;
			end else begin
				case (op)
					OP_FWD: begin
						ldir_d = 1'b1;
						rdir_d = 1'b1;
						ras_d = 1'b0;
						phase_d = PH_LIFT;
					end
					OP_STOP: begin
						ras_d = 1'b0;
						phase_d = PH_STOP;
					end
					default: begin
						pend_d = (op == OP_RIGHT) ? 2'b10 : 2'b01;
						ras_d = 1'b1;
						phase_d = PH_STOP;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			lpow_q <= '0;
			rpow_q <= '0;
			ldir_q <= 1'b1;
			rdir_q <= 1'b1;
			pend_q <= '0;
			ras_q <= 1'b0;
		end else if (op_pop) begin
			phase_q <= phase_d;
			lpow_q <= lpow_d;
			rpow_q <= rpow_d;
			ldir_q <= ldir_d;
			rdir_q <= rdir_d;
			pend_q <= pend_d;
			ras_q <= ras_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= op_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign lrecip = {21'd0, lprod_s2} * {19'd0, DIV_RECIP};
	assign rrecip = {21'd0, rprod_s2} * {19'd0, DIV_RECIP};

	always_ff @(posedge clk) begin
		lpow_s1 <= lpow_d;
		rpow_s1 <= rpow_d;
		ldir_s1 <= ldir_d;
		rdir_s1 <= rdir_d;
		busy_s1 <= (phase_d != PH_IDLE);
		drop_s1 <= drop;
		period_s1 <= pwm_period;

		lprod_s2 <= {12'd0, lpow_s1} * {7'd0, period_s1};
		rprod_s2 <= {12'd0, rpow_s1} * {7'd0, period_s1};
		ldir_s2 <= ldir_s1;
		rdir_s2 <= rdir_s1;
		busy_s2 <= busy_s1;
		drop_s2 <= drop_s1;
		period_s2 <= period_s1;

		lq_s3 <= lrecip[DIV_SHIFT +: 13];
		rq_s3 <= rrecip[DIV_SHIFT +: 13];
		ldir_s3 <= ldir_s2;
		rdir_s3 <= rdir_s2;
		busy_s3 <= busy_s2;
		drop_s3 <= drop_s2;
		period_s3 <= period_s2;
	end

	function automatic logic [11:0] duty_of(input logic [12:0] q, input logic [11:0] period,
			input logic fwd);
		logic [11:0] d;
		d = (q > {1'b0, period}) ? period : q[11:0];
		return fwd ? (period - d) : d;
	endfunction

	assign res_valid = v_s3;
	assign res.left_duty = duty_of(lq_s3, period_s3, ldir_s3);
	assign res.right_duty = duty_of(rq_s3, period_s3, rdir_s3);
	assign res.left_forward = ldir_s3;
	assign res.right_forward = rdir_s3;
	assign res.busy_res = busy_s3;
	assign res.dropped = drop_s3;

	assign status.inflight = {1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3};

endmodule

// ===== hw/rtl/dual_motor_ramp_sequencer.sv =====
// Top level of the dual motor ramp sequencer: configuration registers, front end,
// back end and result queue. Depends on drms_pkg, drms_front, drms_back and drms_fifo.
//
// How the block is used:
// Items (a received serial byte, or a one millisecond tick) are pushed into the
// command side with push while full is low. Every item, byte or tick, gives
// exactly one result: both duty counts (inverted when that wheel runs forward),
// both direction bits, the busy flag and a flag that says a command byte was
// dropped because a sequence was still running. Results come out in order on
// the result side; the oldest is shown while empty is low and leaves with pop.
// An accepted item passes through the command queue, then three back end stages
// (sequence update, power times period, division by 100), then the result queue.
// One item is accepted and one result delivered per cycle, sustained while the
// receiver keeps popping; the sequence state update is the only loop, with its next
// state formed combinationally and registered on each accepted operation.
// When the receiver stalls, the back end keeps taking commands only while the
// result queue still has room for every request in flight; once that credit is
// used up the command queue fills and full rises. Nothing is ever lost.
// Reset clears both queues, leaves the block outside a message, idle, with zero power
// and both wheels forward; pwm_period returns to 200 and floor_power to 25. Users must
// write configuration over the APB port only while the block is idle (unenforced).
module dual_motor_ramp_sequencer
	import drms_pkg::*;
#(
	parameter int unsigned CMD_DEPTH = 4,
	parameter int unsigned RES_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  drms_item_t         cmd_item,
	output logic               empty,
	input  logic               pop,
	output drms_result_t       result
);

	localparam int unsigned CW = $clog2(RES_DEPTH+1);
	localparam int unsigned SW = CW + 1;

	logic [11:0] pwm_period_q;
	logic [6:0] floor_power_q;
	logic cfg_write;

	drms_op_t op;
	logic op_empty, op_pop;
	drms_back_status_t back_status;
	logic res_valid;
	drms_result_t res;
	logic [CW-1:0] res_count;
	logic res_full;
	logic [SW-1:0] reserved;
	logic go;

	// Configuration registers. The register index is the word address bit;
	// the low address bits select bytes within a word and are not decoded.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= PWM_PERIOD_RESET;
			floor_power_q <= FLOOR_POWER_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_PWM_PERIOD: pwm_period_q <= pwdata[11:0];
				REG_FLOOR_POWER: floor_power_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PWM_PERIOD: prdata = {20'd0, pwm_period_q};
			REG_FLOOR_POWER: prdata = {25'd0, floor_power_q};
			default: prdata = '0;
		endcase
	end

	// Front end: framing and classification into the operation queue.
	drms_front #(
		.OP_DEPTH(CMD_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd_item(cmd_item),
		.op_pop(op_pop),
		.op(op),
		.op_empty(op_empty)
	);

	// Credit check: a command only enters the back end when the result queue
	// can take it together with every request already in the pipeline.
	assign reserved = SW'(res_count) + SW'(back_status.inflight);
	assign go = (reserved < SW'(RES_DEPTH));

	drms_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pwm_period(pwm_period_q),
		.floor_power(floor_power_q),
		.op(op),
		.op_empty(op_empty),
		.go(go),
		.op_pop(op_pop),
		.status(back_status),
		.res_valid(res_valid),
		.res(res)
	);

	// Result queue decouples the back end from a stalling receiver.
	drms_fifo #(
		.WIDTH($bits(drms_result_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.wdata(res),
		.pop(pop),
		.rdata(result),
		.full(res_full),
		.empty(empty),
		.count(res_count)
	);

	// A result arriving from the back end must always find room.
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !res_full)
		else $error("result queue overflow");

	// Credit accounting never promises more room than the result queue has.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved <= SW'(RES_DEPTH))
		else $error("result credit exceeded");

	// A dropped command leaves the running sequence untouched, so busy stays set.
	a_drop_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.dropped) |-> result.busy_res)
		else $error("dropped result without busy");

	// The back end only draws commands that are present and covered by credit.
	a_pop_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> (!op_empty && reserved < SW'(RES_DEPTH)))
		else $error("back end popped without credit");

endmodule

// ===== dv/dual_motor_ramp_sequencer_tb.sv =====
// Self-checking testbench for the dual motor ramp sequencer.
// Needs drms_pkg and the block's RTL; a built-in predictor checks every result.
`timescale 1ns / 1ps

module dual_motor_ramp_sequencer_tb;
	import drms_pkg::*;

	// Sequence phases as the predictor tracks them.
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_STOP,
		SEQ_LIFT,
		SEQ_RAMP
	} seq_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Configuration port; pready and prdata are only watched.
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Request side and result side.
	logic push = 1'b0;
	logic full;
	drms_item_t cmd_item = '0;
	logic empty;
	logic pop = 1'b0;
	drms_result_t result;

	// Requests waiting to be driven, and the results they must produce, oldest first.
	drms_item_t pending_requests[$];
	drms_result_t expected_outputs[$];

	int mismatches = 0;
	int send_gap = 0;
	int send_calm = 0;
	int recv_stall = 0;
	int recv_calm = 0;

	// Predictor copy of the block's state and configuration.
	logic [11:0] period_cfg;
	logic [6:0] floor_cfg;
	logic in_msg;
	seq_phase_t seq_phase;
	logic [6:0] left_pwr;
	logic [6:0] right_pwr;
	logic left_fwd;
	logic right_fwd;
	logic [1:0] turn_dirs;
	logic turn_pending;

	dual_motor_ramp_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.cmd_item(cmd_item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Safety net: the slowest legal run needs well under a fifth of this.
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	// Duty count for one wheel. The product is formed at full width, truncated by the
	// division, clipped to the period, and mirrored when the wheel runs forward.
	function automatic logic [11:0] duty_count(logic [6:0] pwr, logic fwd);
		int unsigned d;
		d = 32'(pwr) * 32'(period_cfg) / 100;
		if (d > 32'(period_cfg)) d = 32'(period_cfg);
		if (fwd) d = 32'(period_cfg) - d;
		return d[11:0];
	endfunction

	// One millisecond step of the running sequence.
	function automatic void advance_tick();
		case (seq_phase)
			SEQ_STOP: begin
				if (left_pwr > floor_cfg || right_pwr > floor_cfg) begin
					if (left_pwr > floor_cfg) left_pwr = left_pwr - 7'd1;
					if (right_pwr > floor_cfg) right_pwr = right_pwr - 7'd1;
				end else begin
					// Both wheels at or under the floor: cut power, then either rest
					// or carry on into the lift of a turn.
					left_pwr = '0;
					right_pwr = '0;
					seq_phase = turn_pending ? SEQ_LIFT : SEQ_IDLE;
				end
			end
			SEQ_LIFT: begin
				if (turn_pending) begin
					left_fwd = turn_dirs[1];
					right_fwd = turn_dirs[0];
					turn_pending = 1'b0;
				end
				if (left_pwr < floor_cfg || right_pwr < floor_cfg) begin
					left_pwr = floor_cfg;
					right_pwr = floor_cfg;
				end
				seq_phase = SEQ_RAMP;
			end
			SEQ_RAMP: begin
				if (left_pwr < FULL_POWER) left_pwr = left_pwr + 7'd1;
				if (right_pwr < FULL_POWER) right_pwr = right_pwr + 7'd1;
				if (left_pwr >= FULL_POWER && right_pwr >= FULL_POWER) seq_phase = SEQ_IDLE;
			end
			default: seq_phase = SEQ_IDLE;
		endcase
	endfunction

	// Framing and command decoding of one received byte; returns the dropped flag.
	function automatic logic take_byte(logic [7:0] b);
		logic was_busy;
		was_busy = (seq_phase != SEQ_IDLE);
		if (!in_msg) begin
			if (b == BYTE_OPEN) in_msg = 1'b1;
			return 1'b0;
		end
		if (b == BYTE_CLOSE) begin
			in_msg = 1'b0;
			return 1'b0;
		end
		if (b < BYTE_FWD || b > BYTE_STOP) return 1'b0;
		if (was_busy) return 1'b1;
		if (b == BYTE_FWD) begin
			left_fwd = 1'b1;
			right_fwd = 1'b1;
			turn_pending = 1'b0;
			seq_phase = SEQ_LIFT;
		end else if (b == BYTE_STOP) begin
			turn_pending = 1'b0;
			seq_phase = SEQ_STOP;
		end else begin
			// A right turn drives the left wheel forward and the right one back.
			turn_dirs = (b == BYTE_RIGHT) ? 2'b10 : 2'b01;
			turn_pending = 1'b1;
			seq_phase = SEQ_STOP;
		end
		return 1'b0;
	endfunction

	// Applies one request to the predictor and returns the result it must give.
	function automatic drms_result_t step_motors(drms_item_t req);
		drms_result_t r;
		r.dropped = 1'b0;
		if (req.cmd) advance_tick();
		else r.dropped = take_byte(req.rx_byte);
		r.left_duty = duty_count(left_pwr, left_fwd);
		r.right_duty = duty_count(right_pwr, right_fwd);
		r.left_forward = left_fwd;
		r.right_forward = right_fwd;
		r.busy_res = (seq_phase != SEQ_IDLE);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatches < 40) $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
		mismatches++;
	endtask

	task automatic check_result(drms_result_t got);
		drms_result_t want;
		if (expected_outputs.size() == 0) begin
			report_mismatch("unexpected result", 1, 0);
			return;
		end
		want = expected_outputs.pop_front();
		if (got.left_duty !== want.left_duty)
			report_mismatch("left_duty", got.left_duty, want.left_duty);
		if (got.right_duty !== want.right_duty)
			report_mismatch("right_duty", got.right_duty, want.right_duty);
		if (got.left_forward !== want.left_forward)
			report_mismatch("left_forward", got.left_forward, want.left_forward);
		if (got.right_forward !== want.right_forward)
			report_mismatch("right_forward", got.right_forward, want.right_forward);
		if (got.busy_res !== want.busy_res)
			report_mismatch("busy_res", got.busy_res, want.busy_res);
		if (got.dropped !== want.dropped)
			report_mismatch("dropped", got.dropped, want.dropped);
	endtask

	// Idle length for either side: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Request driver. A request is taken at an edge with push high and full low; it is
	// fed to the predictor at that same edge. A request that is still waiting is held.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_gap <= 0;
			send_calm <= 0;
		end else begin
			if (push && !full) expected_outputs.push_back(step_motors(cmd_item));
			// Now and then the sender runs flat out for a while.
			if (send_calm > 0) send_calm <= send_calm - 1;
			else if ($urandom_range(0, 99) == 0) send_calm <= $urandom_range(20, 100);
			if (!push || !full) begin
				if (send_gap > 0) begin
					push <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_requests.size() != 0) begin
					cmd_item <= pending_requests.pop_front();
					push <= 1'b1;
					send_gap <= (send_calm > 0) ? 0 : pick_gap();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure on pop.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			recv_stall <= 0;
			recv_calm <= 0;
		end else begin
			if (pop && !empty) check_result(result);
			if (recv_calm > 0) recv_calm <= recv_calm - 1;
			else if ($urandom_range(0, 99) == 0) recv_calm <= $urandom_range(20, 100);
			if (recv_stall > 0) begin
				pop <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				pop <= 1'b1;
				recv_stall <= (recv_calm > 0) ? 0 : pick_gap();
			end
		end
	end

	function automatic drms_item_t byte_req(logic [7:0] b);
		drms_item_t it;
		it.cmd = 1'b0;
		it.rx_byte = b;
		return it;
	endfunction

	// The byte lane carries junk on ticks; the block must ignore it.
	function automatic drms_item_t tick_req();
		drms_item_t it;
		it.cmd = 1'b1;
		it.rx_byte = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// Waits until every request has been taken and every result has come back.
	task automatic drain();
		do @(negedge clk);
		while (pending_requests.size() != 0 || push || expected_outputs.size() != 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// Drains, then ticks any running sequence to its end so that the registers can
	// be rewritten with the block at rest.
	task automatic settle();
		drain();
		while (seq_phase != SEQ_IDLE) begin
			repeat (20) pending_requests.push_back(tick_req());
			drain();
		end
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_PWM_PERIOD) period_cfg = val[11:0];
		else floor_cfg = val[6:0];
	endtask

	// A message: open, one command, then mostly ticks with the odd byte thrown in
	// (further commands are dropped while the sequence runs), mostly closed at the end.
	// Most messages are short; some carry enough ticks for a whole stop, turn and ramp.
	task automatic add_message();
		logic [7:0] commands[4];
		int n;
		int r;
		commands = '{BYTE_FWD, BYTE_RIGHT, BYTE_LEFT, BYTE_STOP};
		pending_requests.push_back(byte_req(BYTE_OPEN));
		pending_requests.push_back(byte_req(commands[$urandom_range(0, 3)]));
		n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 30) : $urandom_range(60, 220);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 85) pending_requests.push_back(tick_req());
			else if (r < 94) pending_requests.push_back(byte_req(commands[$urandom_range(0, 3)]));
			else pending_requests.push_back(byte_req(8'($urandom_range(0, 255))));
		end
		if ($urandom_range(0, 3) != 0) pending_requests.push_back(byte_req(BYTE_CLOSE));
	endtask

	// Loose requests: random bytes, framing and command bytes out of order, stray ticks.
	task automatic add_noise();
		logic [7:0] specials[6];
		int r;
		specials = '{BYTE_OPEN, BYTE_CLOSE, BYTE_FWD, BYTE_RIGHT, BYTE_LEFT, BYTE_STOP};
		repeat ($urandom_range(1, 6)) begin
			r = $urandom_range(0, 2);
			if (r == 0) pending_requests.push_back(tick_req());
			else if (r == 1) pending_requests.push_back(byte_req(8'($urandom_range(0, 255))));
			else pending_requests.push_back(byte_req(specials[$urandom_range(0, 5)]));
		end
	endtask

	initial begin
		int unsigned periods[7];
		int unsigned floors[7];
		int base;

		// Predictor starts from the reset state of the block.
		period_cfg = PWM_PERIOD_RESET;
		floor_cfg = FLOOR_POWER_RESET;
		in_msg = 1'b0;
		seq_phase = SEQ_IDLE;
		left_pwr = '0;
		right_pwr = '0;
		left_fwd = 1'b1;
		right_fwd = 1'b1;
		turn_dirs = '0;
		turn_pending = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests at the reset configuration: ticks at rest, bytes outside
		// a message, a repeated open and junk inside one, a stop from zero power,
		// commands dropped while busy, and framing acted on while busy.
		pending_requests.push_back(tick_req());
		pending_requests.push_back(byte_req(BYTE_FWD));
		pending_requests.push_back(byte_req(BYTE_CLOSE));
		pending_requests.push_back(byte_req(8'h00));
		pending_requests.push_back(byte_req(BYTE_OPEN));
		pending_requests.push_back(byte_req(BYTE_OPEN));
		pending_requests.push_back(byte_req(8'hFF));
		pending_requests.push_back(byte_req(BYTE_STOP));
		pending_requests.push_back(byte_req(BYTE_FWD));
		pending_requests.push_back(tick_req());
		pending_requests.push_back(byte_req(BYTE_FWD));
		pending_requests.push_back(tick_req());
		pending_requests.push_back(tick_req());
		pending_requests.push_back(byte_req(BYTE_CLOSE));
		pending_requests.push_back(byte_req(BYTE_RIGHT));
		pending_requests.push_back(byte_req(BYTE_OPEN));
		pending_requests.push_back(byte_req(BYTE_LEFT));
		pending_requests.push_back(byte_req(BYTE_RIGHT));
		pending_requests.push_back(byte_req(BYTE_STOP));
		pending_requests.push_back(tick_req());
		settle();

		// Register settings: the reset values written back, the extremes (zero
		// floor, floor at and above full power, a zero period), then two at random.
		periods = '{200, 4095, 1, 0, 4095, 0, 0};
		floors = '{25, 0, 100, 127, 127, 0, 0};
		periods[5] = $urandom_range(1, 4095);
		floors[5] = $urandom_range(0, 100);
		periods[6] = $urandom_range(1, 4095);
		floors[6] = $urandom_range(0, 100);

		for (int p = 0; p < 7; p++) begin
			write_reg(REG_PWM_PERIOD, periods[p]);
			write_reg(REG_FLOOR_POWER, floors[p]);
			@(negedge clk);
			base = pending_requests.size();
			while (pending_requests.size() - base < 100) begin
				if ($urandom_range(0, 99) < 80) add_message();
				else add_noise();
			end
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_outputs.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
